// ===== rtl/ckc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckc_pkg
// Shared types, constants and keyword table for the C keyword counter.
// ----------------------------------------------------------------------------
package ckc_pkg;

    localparam int MAX_WORD    = 100;
    localparam int NUM_KEYS    = 11;
    localparam int COUNT_WIDTH = 32;

    localparam int KEY_CHARS = 8;
    localparam int KEY_SLOTS = 16;
    localparam int LEN_W     = $clog2(MAX_WORD);
    localparam int KLEN_W    = $clog2(KEY_CHARS + 1);
    localparam int IDX_W     = 4;

    // Scanner state
    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_WORD,
        MODE_QUOTE,
        MODE_ESC,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_STAR
    } t_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [3:0]  keyword_index;
        logic [31:0] count;
        logic        is_dump;
        logic        last;
    } t_out;

    // Finished word handed from the scanner to the cell row
    typedef struct packed {
        logic                        valid;
        logic [KLEN_W-1:0]           len;
        logic [KEY_CHARS-1:0][7:0]   chars;
    } t_req;

    // Keyword text, first character in the top byte, zero padded
    function automatic logic [KEY_CHARS*8-1:0] key_word(input int k);
        logic [KEY_CHARS*8-1:0] w;
        begin
            case (k)
                0:       w = {"auto", 32'd0};
                1:       w = {"break", 24'd0};
                2:       w = {"case", 32'd0};
                3:       w = {"char", 32'd0};
                4:       w = {"const", 24'd0};
                5:       w = "continue";
                6:       w = {"default", 8'd0};
                7:       w = "unsigned";
                8:       w = {"void", 32'd0};
                9:       w = "volatile";
                10:      w = {"while", 24'd0};
                default: w = '0;
            endcase
            return w;
        end
    endfunction

    function automatic logic [KLEN_W-1:0] key_len(input int k);
        logic [KLEN_W-1:0] n;
        begin
            case (k)
                0, 2, 3, 8:  n = KLEN_W'(4);
                1, 4, 10:    n = KLEN_W'(5);
                6:           n = KLEN_W'(7);
                5, 7, 9:     n = KLEN_W'(8);
                default:     n = '0;
            endcase
            return n;
        end
    endfunction

endpackage

// ===== rtl/ckc_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckc_scanner
// Tokenizer: tracks strings, comments and words one character at a time and
// registers each finished candidate word for the cell row.
// ----------------------------------------------------------------------------
module ckc_scanner (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_take,
    input  ckc_pkg::t_in i_data,
    input  logic         i_adv,
    output ckc_pkg::t_req o_req
);
    import ckc_pkg::*;

    t_mode                     r_mode, n_mode;
    logic                      r_quote, n_quote;
    logic [KEY_CHARS-1:0][7:0] r_wchars, n_wchars;
    logic [LEN_W-1:0]          r_wlen, n_wlen;
    logic                      r_wcnt, n_wcnt;
    t_req                      r_req, n_req;

    logic [7:0]                c;
    logic                      is_letter, is_wchar, is_space;
    logic                      fin;
    logic [KEY_CHARS-1:0][7:0] fin_chars;
    logic [LEN_W-1:0]          fin_len;
    logic                      fin_cnt;
    logic                      cont;
    t_mode                     mode2;
    logic [LEN_W-1:0]          grown;

    // Classify the character
    always_comb begin
        c         = i_data.ch;
        is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        is_wchar  = is_letter || (c >= "0" && c <= "9") || c == "_";
        is_space  = c == " " || (c >= 8'd9 && c <= 8'd13);
    end

    // Hold scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NORMAL;
            r_quote <= 1'b0;
            r_wlen  <= '0;
            r_wcnt  <= 1'b0;
            r_req   <= '0;
        end else begin
            r_mode  <= n_mode;
            r_quote <= n_quote;
            r_wlen  <= n_wlen;
            r_wcnt  <= n_wcnt;
            r_req   <= n_req;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wchars <= n_wchars;
    end

    // Next state and finished-word request
    always_comb begin
        n_mode    = r_mode;
        n_quote   = r_quote;
        n_wchars  = r_wchars;
        n_wlen    = r_wlen;
        n_wcnt    = r_wcnt;
        fin       = 1'b0;
        fin_chars = r_wchars;
        fin_len   = r_wlen;
        fin_cnt   = r_wcnt;
        cont      = 1'b1;
        mode2     = r_mode;
        grown     = r_wlen + LEN_W'(1);

        if (i_data.end_of_text) begin
            fin     = (r_mode == MODE_WORD);
            n_mode  = MODE_NORMAL;
            n_quote = 1'b0;
            n_wlen  = '0;
            n_wcnt  = 1'b0;
        end else begin
            // Close a word or a lone slash first
            if (r_mode == MODE_WORD) begin
                if (is_wchar) begin
                    cont   = 1'b0;
                    n_wlen = grown;
                    if (r_wlen < LEN_W'(KEY_CHARS)) begin
                        n_wchars[r_wlen[$clog2(KEY_CHARS)-1:0]] = c;
                    end
                    fin_chars = n_wchars;
                    fin_len   = grown;
                    if (grown >= LEN_W'(MAX_WORD - 1)) begin
                        fin    = 1'b1;
                        n_mode = MODE_NORMAL;
                    end
                end else begin
                    fin   = 1'b1;
                    mode2 = MODE_NORMAL;
                end
            end else if (r_mode == MODE_SLASH) begin
                if (c == "*") begin
                    cont   = 1'b0;
                    n_mode = MODE_COMMENT;
                end else begin
                    mode2 = MODE_NORMAL;
                end
            end

            // Handle the character in the resulting mode
            if (cont) begin
                n_mode = mode2;
                case (mode2)
                    MODE_QUOTE: begin
                        if (c == "\\") begin
                            n_mode = MODE_ESC;
                        end else if (c == (r_quote ? 8'h27 : 8'h22)) begin
                            n_mode = MODE_NORMAL;
                        end
                    end
                    MODE_ESC: begin
                        n_mode = MODE_QUOTE;
                    end
                    MODE_COMMENT: begin
                        if (c == "*") begin
                            n_mode = MODE_STAR;
                        end
                    end
                    MODE_STAR: begin
                        if (c == "/") begin
                            n_mode = MODE_NORMAL;
                        end else if (c != "*") begin
                            n_mode = MODE_COMMENT;
                        end
                    end
                    default: begin
                        n_mode = MODE_NORMAL;
                        if (is_space) begin
                            n_mode = MODE_NORMAL;
                        end else if (is_letter || c == "_" || c == "#") begin
                            n_wchars[0] = c;
                            n_wlen      = LEN_W'(1);
                            n_wcnt      = is_letter;
                            n_mode      = MODE_WORD;
                        end else if (c == 8'h22 || c == 8'h27) begin
                            n_quote = (c == 8'h27);
                            n_mode  = MODE_QUOTE;
                        end else if (c == "/") begin
                            n_mode = MODE_SLASH;
                        end
                    end
                endcase
            end
        end

        // Advance the request register
        n_req = r_req;
        if (i_adv) begin
            n_req.valid = 1'b0;
        end
        if (i_take) begin
            n_req.valid = fin && fin_cnt && fin_len != '0 &&
                          fin_len <= LEN_W'(KEY_CHARS);
            n_req.len   = KLEN_W'(fin_len);
            n_req.chars = fin_chars;
        end

        // Hold state when nothing is taken
        if (!i_take) begin
            n_mode   = r_mode;
            n_quote  = r_quote;
            n_wchars = r_wchars;
            n_wlen   = r_wlen;
            n_wcnt   = r_wcnt;
        end
    end

    assign o_req = r_req;

endmodule

// ===== rtl/ckc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckc_cell
// One keyword slot: compares the finished word with its keyword, holds the
// saturating count and passes the count down the row during a dump.
// ----------------------------------------------------------------------------
module ckc_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ckc_pkg::t_req                       i_req,
    input  logic                                i_adv,
    input  logic [ckc_pkg::KEY_CHARS*8-1:0]     i_key_word,
    input  logic [ckc_pkg::KLEN_W-1:0]          i_key_len,
    input  logic                                i_shift,
    input  logic [ckc_pkg::COUNT_WIDTH-1:0]     i_shift_cnt,
    output logic                                o_hit,
    output logic [ckc_pkg::COUNT_WIDTH-1:0]     o_next_cnt,
    output logic [ckc_pkg::COUNT_WIDTH-1:0]     o_cnt
);
    import ckc_pkg::*;

    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                   eq;

    // Compare the word with this slot's keyword
    always_comb begin
        eq = (i_req.len == i_key_len);
        for (int i = 0; i < KEY_CHARS; i++) begin
            if (KLEN_W'(i) < i_req.len &&
                i_req.chars[i] != i_key_word[KEY_CHARS*8-1-8*i -: 8]) begin
                eq = 1'b0;
            end
        end
        o_hit      = i_req.valid && eq;
        o_next_cnt = (&r_cnt) ? r_cnt : r_cnt + COUNT_WIDTH'(1);
    end

    // Count on a match, shift during a dump
    always_comb begin
        n_cnt = r_cnt;
        if (i_shift) begin
            n_cnt = i_shift_cnt;
        end else if (i_adv && o_hit) begin
            n_cnt = o_next_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_cnt = r_cnt;

endmodule

// ===== rtl/c_keyword_counter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_keyword_counter_unit
// Counts whole-word C keywords in a character stream and dumps the counts.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with i_data = {ch, end_of_text}, one
// character per transfer. Output channel: o_valid / i_stall with
// o_res = {keyword_index, count, is_dump, last}.
// A scanner register stage tracks strings, comments and words; a finished
// word goes to a row of NUM_KEYS cells, each holding one keyword count.
// Throughput: one character per cycle while no dump runs and the output
// drains. A keyword match passes through the scanner's request register
// and then the output register before it appears on o_res.
// End of text: any open word is finished first, then the row shifts its
// counts out through cell 0, one dump entry per unstalled cycle (NUM_KEYS
// entries, last marked), clearing every count; input is stalled meanwhile.
// Reset clears all counts and returns the scanner to normal mode.
// When the receiver stalls, the output register holds its result and the
// input is stalled as soon as a pending match cannot move on.
// ----------------------------------------------------------------------------
module c_keyword_counter_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ckc_pkg::t_in  i_data,
    output logic          o_stall,
    output logic          o_valid,
    output ckc_pkg::t_out o_res,
    input  logic          i_stall
);
    import ckc_pkg::*;

    t_req                   req;
    logic                   adv;
    logic                   take;
    logic                   shift;
    logic                   r_dump, n_dump;
    logic [IDX_W-1:0]       r_didx, n_didx;
    logic                   r_out_valid, n_out_valid;
    t_out                   r_out, n_out;

    logic [NUM_KEYS-1:0]    hit;
    logic [COUNT_WIDTH-1:0] next_cnt [NUM_KEYS];
    logic [COUNT_WIDTH-1:0] cnt      [NUM_KEYS];
    logic [COUNT_WIDTH-1:0] chain_in [NUM_KEYS];
    logic                   hit_any;
    logic [IDX_W-1:0]       hit_idx;
    logic [COUNT_WIDTH-1:0] hit_cnt;

    // Output slot free next cycle
    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = r_dump || (req.valid && !adv);
    assign take    = i_valid && !o_stall;
    assign shift   = r_dump && !req.valid && adv;

    ckc_scanner u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_data  (i_data),
        .i_adv   (adv),
        .o_req   (req)
    );

    // Row of keyword cells, counts shift toward cell 0
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_cell
        if (k == NUM_KEYS - 1) begin : g_top
            assign chain_in[k] = '0;
        end else begin : g_mid
            assign chain_in[k] = cnt[k+1];
        end

        ckc_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_req       (req),
            .i_adv       (adv),
            .i_key_word  (key_word(k)),
            .i_key_len   (key_len(k)),
            .i_shift     (shift),
            .i_shift_cnt (chain_in[k]),
            .o_hit       (hit[k]),
            .o_next_cnt  (next_cnt[k]),
            .o_cnt       (cnt[k])
        );
    end

    // Select the matching cell
    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        hit_cnt = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (hit[k]) begin
                hit_any = 1'b1;
                hit_idx = hit_idx | IDX_W'(k);
                hit_cnt = hit_cnt | next_cnt[k];
            end
        end
    end

    // Dump sequencing and output register
    always_comb begin
        n_dump      = r_dump;
        n_didx      = r_didx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (take && i_data.end_of_text) begin
            n_dump = 1'b1;
        end
        if (adv) begin
            n_out_valid = 1'b0;
            if (req.valid && hit_any) begin
                n_out_valid         = 1'b1;
                n_out.keyword_index = hit_idx;
                n_out.count         = 32'(hit_cnt);
                n_out.is_dump       = 1'b0;
                n_out.last          = 1'b0;
            end else if (shift) begin
                n_out_valid         = 1'b1;
                n_out.keyword_index = r_didx;
                n_out.count         = 32'(cnt[0]);
                n_out.is_dump       = 1'b1;
                n_out.last          = (r_didx == IDX_W'(NUM_KEYS - 1));
                n_didx              = r_didx + IDX_W'(1);
                if (r_didx == IDX_W'(NUM_KEYS - 1)) begin
                    n_dump = 1'b0;
                    n_didx = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dump      <= 1'b0;
            r_didx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_dump      <= n_dump;
            r_didx      <= n_didx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

// ===== rtl/ckc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckc_checker
// Port-level checks for the C keyword counter, bound to the top level.
// ----------------------------------------------------------------------------
module ckc_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ckc_pkg::t_in  i_data,
    input  logic          o_stall,
    input  logic          o_valid,
    input  ckc_pkg::t_out o_res,
    input  logic          i_stall
);
    import ckc_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res))
        else $error("stalled result changed");

    // Mark last only on dump entries
    a_last_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.last |-> o_res.is_dump)
        else $error("last set on a match update");

    // Stall input while a dump is still running
    a_dump_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.is_dump && !o_res.last |-> o_stall)
        else $error("input open during dump");

    // Advance dump entries back to back
    a_dump_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_res.is_dump && !o_res.last |=>
        o_valid && o_res.is_dump &&
        o_res.keyword_index == $past(o_res.keyword_index) + 4'd1)
        else $error("dump sequence broken");

    // Keep match indexes inside the table
    a_match_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.is_dump |-> o_res.keyword_index < 4'(NUM_KEYS))
        else $error("match index out of range");

endmodule

bind c_keyword_counter_unit ckc_checker u_ckc_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the C keyword counter. A short table of characters
// walks the special cases of the scanner (comment and string edges, word
// terminators, end of text inside a word or string). Random C-like fragments
// follow: keywords, near misses, strings, comments, one over-long word and
// raw bytes, with end-of-text markers dropped in, some mid-fragment. A
// scanner model in this file predicts every keyword update and dump entry;
// each output transfer is compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module testbench;

    import ckc_pkg::*;

    localparam int HOLD_LEN   = 80;    // long receiver hold-off, in cycles
    localparam int QUIET_MAX  = 2000;  // cycles without any transfer
    localparam int DRAIN_WAIT = 30;    // settle time once nothing is pending

    localparam logic [7:0] CH_DQUOTE = "\"";
    localparam logic [7:0] CH_SQUOTE = "'";
    localparam logic [7:0] CH_BSLASH = "\\";
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_HASH   = "#";
    localparam logic [7:0] CH_USCORE = "_";

    localparam string LETTERS    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam string WORD_CHARS = "abcdefghijklmnopqrstuvwxyzQRSTUVWXYZ0123456789_";
    localparam string DELIMS     = " \t\n\v\f\015;,(){}[]=+-<>!&|:.?~%^";
    localparam string PLAIN_TEXT = "abcvoidwhile XYZ 0189 #_;*/";
    localparam string ANY_TEXT   = "ab z0_#*/\"'\\n";

    typedef enum logic [3:0] {
        KW_AUTO, KW_BREAK, KW_CASE, KW_CHAR, KW_CONST, KW_CONTINUE,
        KW_DEFAULT, KW_UNSIGNED, KW_VOID, KW_VOLATILE, KW_WHILE
    } t_keyword;

    typedef struct packed {
        t_in  item;
        logic hand;   // result typed in below
        t_out res;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    t_in  i_data  = '0;
    logic o_stall;
    logic o_valid;
    t_out o_res;
    logic i_stall = 1'b0;

    c_keyword_counter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_res   (o_res),
        .i_stall (i_stall)
    );

    // Scanner model state
    string kw_names [KEY_SLOTS] = '{
        "auto", "break", "case", "char", "const", "continue",
        "default", "unsigned", "void", "volatile", "while",
        "", "", "", "", ""
    };
    t_mode                  scan_st     = MODE_NORMAL;
    logic                   quote_sq    = 1'b0;
    logic [7:0]             word_buf [KEY_CHARS] = '{default: '0};
    int unsigned            word_len    = 0;
    logic                   word_letter = 1'b0;
    logic [COUNT_WIDTH-1:0] kw_count [KEY_SLOTS] = '{default: '0};

    t_out       new_counts [$];
    t_out       pending_counts [$];
    logic [7:0] text_q [$];

    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    int  hold_asked   = 0;
    int  hold_served  = 0;
    int  hold_left    = 0;
    int  quiet        = 0;
    bit  failed       = 1'b0;

    // Directed walk through the scanner's corner cases
    t_row dir_rows [27] = '{
        // dump right after reset, ch ignored
        '{'{"Z", 1'b1}, 1'b0, '0},
        // word closed by a slash that opens a star-run comment
        '{'{"c", 1'b0}, 1'b0, '0},
        '{'{"a", 1'b0}, 1'b0, '0},
        '{'{"s", 1'b0}, 1'b0, '0},
        '{'{"e", 1'b0}, 1'b0, '0},
        '{'{"/", 1'b0}, 1'b1, '{KW_CASE, 32'd1, 1'b0, 1'b0}},
        '{'{"*", 1'b0}, 1'b0, '0},
        '{'{"*", 1'b0}, 1'b0, '0},
        '{'{"/", 1'b0}, 1'b0, '0},
        // word closed by a top-bit byte
        '{'{"v", 1'b0}, 1'b0, '0},
        '{'{"o", 1'b0}, 1'b0, '0},
        '{'{"i", 1'b0}, 1'b0, '0},
        '{'{"d", 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b0}, 1'b1, '{KW_VOID, 32'd1, 1'b0, 1'b0}},
        // string with an escaped quote, text ends while it is open
        '{'{"\"", 1'b0}, 1'b0, '0},
        '{'{"\\", 1'b0}, 1'b0, '0},
        '{'{"\"", 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b1}, 1'b0, '0},
        // lone slash, short word, hash word closed by a zero byte
        '{'{"/", 1'b0}, 1'b0, '0},
        '{'{"x", 1'b0}, 1'b0, '0},
        '{'{"#", 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        // text ends inside a keyword
        '{'{"c", 1'b0}, 1'b0, '0},
        '{'{"h", 1'b0}, 1'b0, '0},
        '{'{"a", 1'b0}, 1'b0, '0},
        '{'{"r", 1'b0}, 1'b0, '0},
        '{'{8'h7F, 1'b1}, 1'b0, '0}
    };

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void append_char(input logic [7:0] c);
        if (word_len < KEY_CHARS) word_buf[word_len] = c;
        word_len++;
    endfunction

    // Close the open word and count it if it is a keyword
    function automatic void close_word();
        logic hit;
        scan_st = MODE_NORMAL;
        if (!word_letter || word_len == 0 || word_len > KEY_CHARS) return;
        for (int k = 0; k < NUM_KEYS && k < KEY_SLOTS; k++) begin
            if (kw_names[k].len() != word_len) continue;
            hit = 1'b1;
            for (int i = 0; i < word_len; i++) begin
                if (8'(kw_names[k][i]) != word_buf[i]) hit = 1'b0;
            end
            if (hit) begin
                if (kw_count[k] != '1) kw_count[k] = kw_count[k] + 1'b1;
                new_counts.push_back('{keyword_index: 4'(k), count: 32'(kw_count[k]),
                                       is_dump: 1'b0, last: 1'b0});
                return;
            end
        end
    endfunction

    // Advance the scanner by one transfer and collect the counts it emits
    function automatic void scan_char(input t_in item);
        logic [7:0] c;
        c = item.ch;
        new_counts.delete();
        if (item.end_of_text) begin
            if (scan_st == MODE_WORD) close_word();
            for (int k = 0; k < NUM_KEYS && k < KEY_SLOTS; k++) begin
                new_counts.push_back('{keyword_index: 4'(k), count: 32'(kw_count[k]),
                                       is_dump: 1'b1,
                                       last: (k + 1 == NUM_KEYS || k + 1 == KEY_SLOTS)});
            end
            kw_count    = '{default: '0};
            scan_st     = MODE_NORMAL;
            quote_sq    = 1'b0;
            word_len    = 0;
            word_letter = 1'b0;
            return;
        end

        // a word either grows or ends; the ending character is read again below
        if (scan_st == MODE_WORD) begin
            if (is_letter(c) || (c >= "0" && c <= "9") || c == CH_USCORE) begin
                append_char(c);
                if (word_len >= MAX_WORD - 1) close_word();
                return;
            end
            close_word();
        end else if (scan_st == MODE_SLASH) begin
            if (c == CH_STAR) begin
                scan_st = MODE_COMMENT;
                return;
            end
            scan_st = MODE_NORMAL;
        end

        case (scan_st)
            MODE_QUOTE: begin
                if (c == CH_BSLASH) scan_st = MODE_ESC;
                else if (c == (quote_sq ? CH_SQUOTE : CH_DQUOTE)) scan_st = MODE_NORMAL;
            end
            MODE_ESC: scan_st = MODE_QUOTE;
            MODE_COMMENT: begin
                if (c == CH_STAR) scan_st = MODE_STAR;
            end
            MODE_STAR: begin
                if (c == CH_SLASH) scan_st = MODE_NORMAL;
                else if (c != CH_STAR) scan_st = MODE_COMMENT;
            end
            default: begin
                // whitespace and any other byte drop through as lone tokens
                scan_st = MODE_NORMAL;
                if (is_letter(c) || c == CH_USCORE || c == CH_HASH) begin
                    word_len    = 0;
                    word_letter = is_letter(c);
                    append_char(c);
                    scan_st = MODE_WORD;
                    if (word_len >= MAX_WORD - 1) close_word();
                end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                    quote_sq = (c == CH_SQUOTE);
                    scan_st  = MODE_QUOTE;
                end else if (c == CH_SLASH) begin
                    scan_st = MODE_SLASH;
                end
            end
        endcase
    endfunction

    function automatic logic [7:0] pick(input string pool);
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic void push_word(input string w);
        for (int i = 0; i < w.len(); i++) text_q.push_back(w[i]);
    endfunction

    // Append one C-like fragment, closed by a delimiter
    function automatic void build_fragment();
        int unsigned sel;
        int unsigned base;
        string       w;
        logic [7:0]  q;
        sel = $urandom_range(0, 99);
        w   = kw_names[$urandom_range(0, NUM_KEYS - 1)];
        if (sel < 40) begin
            push_word(w);
        end else if (sel < 50) begin
            // near miss: glued prefix or suffix, or a capital first letter
            case ($urandom_range(0, 2))
                0: begin
                    text_q.push_back(pick("_#"));
                    push_word(w);
                end
                1: begin
                    push_word(w);
                    text_q.push_back(pick(WORD_CHARS));
                end
                default: begin
                    base = text_q.size();
                    push_word(w);
                    text_q[base] = text_q[base] ^ 8'h20;
                end
            endcase
        end else if (sel < 60) begin
            text_q.push_back(pick(LETTERS));
            repeat ($urandom_range(0, 11)) text_q.push_back(pick(WORD_CHARS));
        end else if (sel < 70) begin
            // string or character literal with escapes and the other quote
            q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            text_q.push_back(q);
            repeat ($urandom_range(0, 8)) begin
                case ($urandom_range(0, 3))
                    0: begin
                        text_q.push_back(CH_BSLASH);
                        text_q.push_back(pick(ANY_TEXT));
                    end
                    1:       text_q.push_back(q == CH_SQUOTE ? CH_DQUOTE : CH_SQUOTE);
                    default: text_q.push_back(pick(PLAIN_TEXT));
                endcase
            end
            text_q.push_back(q);
        end else if (sel < 80) begin
            // comment with stray stars and slashes, closed by a star run
            text_q.push_back(CH_SLASH);
            text_q.push_back(CH_STAR);
            repeat ($urandom_range(0, 8)) begin
                case ($urandom_range(0, 3))
                    0:       text_q.push_back(CH_STAR);
                    1:       push_word(w);
                    default: text_q.push_back(pick(ANY_TEXT));
                endcase
            end
            repeat ($urandom_range(1, 3)) text_q.push_back(CH_STAR);
            text_q.push_back(CH_SLASH);
        end else if (sel < 88) begin
            repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
        end else if (sel < 94) begin
            text_q.push_back(CH_HASH);
            push_word(w);
        end else begin
            text_q.push_back(CH_SLASH);
        end
        text_q.push_back(pick(DELIMS));
    endfunction

    // Offer one item, wait for its transfer, then queue what it must produce
    task automatic feed(input t_in item, input logic hand = 1'b0, input t_out hand_res = '0);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (o_stall);
        scan_char(item);
        if (hand) pending_counts.push_back(hand_res);
        else foreach (new_counts[i]) pending_counts.push_back(new_counts[i]);
    endtask

    task automatic feed_text();
        t_in it;
        foreach (text_q[i]) begin
            it.ch          = text_q[i];
            it.end_of_text = 1'b0;
            feed(it);
        end
    endtask

    task automatic feed_end();
        t_in it;
        it.ch          = 8'($urandom_range(0, 255));
        it.end_of_text = 1'b1;
        feed(it);
    endtask

    // Compare one output transfer with the oldest pending count
    function automatic void check_count(input t_out got);
        t_out want;
        if (pending_counts.size() == 0) begin
            $error("unexpected result: keyword_index %0d count %0d is_dump %0b last %0b",
                   got.keyword_index, got.count, got.is_dump, got.last);
            failed = 1'b1;
            return;
        end
        want = pending_counts.pop_front();
        if (got.keyword_index !== want.keyword_index) begin
            $error("keyword_index: expected %0d, got %0d", want.keyword_index, got.keyword_index);
            failed = 1'b1;
        end
        if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            failed = 1'b1;
        end
        if (got.is_dump !== want.is_dump) begin
            $error("is_dump: expected %0b, got %0b", want.is_dump, got.is_dump);
            failed = 1'b1;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            failed = 1'b1;
        end
    endfunction

    always #5 i_clk = ~i_clk;

    // Receiver: check transfers, stall at random or for a requested hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) check_count(o_res);
            if (hold_served != hold_asked) begin
                hold_served = hold_asked;
                hold_left   = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
            end
        end
    end

    // Watchdog: end the run after a long stretch without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_MAX) begin
            $error("timeout with %0d results outstanding", pending_counts.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int unsigned frag;
        int unsigned rnd_items;
        logic        cut;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, light idling on both sides
        tx_idle_pct  = 11;
        rx_stall_pct = 11;
        foreach (dir_rows[r]) feed(dir_rows[r].item, dir_rows[r].hand, dir_rows[r].res);

        // random fragments, idling pattern rotating every three fragments
        frag      = 0;
        rnd_items = 0;
        while (rnd_items < 100) begin
            case ((frag / 3) % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 68; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 68; end
                default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
            endcase

            // long receiver hold while the sender keeps pushing
            if (frag == 1) hold_asked++;

            // drain completely before going on
            if (frag == 8) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while (pending_counts.size() != 0);
            end

            text_q.delete();
            if (frag == 2) begin
                // over-long word: its first piece ends on the longest length,
                // the keyword behind it starts a fresh word
                text_q.push_back(pick(LETTERS));
                repeat (MAX_WORD - 2) text_q.push_back(pick(WORD_CHARS));
                push_word(kw_names[$urandom_range(0, NUM_KEYS - 1)]);
                text_q.push_back(pick(DELIMS));
            end else if (frag == 1) begin
                // a run of keywords piles up matches behind the held receiver
                repeat (4) begin
                    push_word(kw_names[$urandom_range(0, NUM_KEYS - 1)]);
                    text_q.push_back(pick(DELIMS));
                end
                rnd_items += text_q.size();
            end else begin
                build_fragment();
                rnd_items += text_q.size();
            end

            // now and then end the text, sometimes in the middle of a fragment
            cut = ($urandom_range(0, 7) == 0);
            if (cut && text_q.size() > 1 && $urandom_range(0, 1))
                repeat ($urandom_range(1, text_q.size() - 1)) void'(text_q.pop_back());
            feed_text();
            if (cut) begin
                feed_end();
                rnd_items++;
            end
            frag++;
        end
        feed_end();

        // wait for every pending count, then let the block settle
        i_valid      <= 1'b0;
        rx_stall_pct = 0;
        do @(posedge i_clk); while (pending_counts.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (!failed) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
